// ----- src/wamf_pkg.sv -----
// Shared constants, cell control types and codes for the weighted average / median filter.
`default_nettype none
package wamf_pkg;

    localparam int MAX_WINDOW_DEF = 8;
    localparam int SAMPLE_W       = 32;
    localparam int WEIGHT_W       = 16;
    localparam int WSUM_OUT_W     = 19;
    localparam int PROD_W         = 48;
    localparam int MODE_W         = 2;
    localparam int WSIZE_W        = 4;
    localparam int ACTION_W       = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;
    localparam logic [WSIZE_W-1:0]  WSIZE_RESET = 4'd8;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MED  = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

    // What a window cell loads in the next cycle
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_RIGHT = 3'd1,
        OP_LEFT  = 3'd2,
        OP_LOAD  = 3'd3,
        OP_WRAP  = 3'd4,
        OP_CLEAR = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t samp_op;
        cell_op_t wgt_op;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        JOB_AVG  = 2'd0,
        JOB_MED  = 2'd1,
        JOB_WSUM = 2'd2
    } job_t;

endpackage
`default_nettype wire

// ----- src/wamf_cell.sv -----
// One window cell: holds a sample and its weight and trades them with its neighbors.
`default_nettype none
module wamf_cell (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wamf_pkg::cell_ctl_t              ctl,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] right_sample,
    input  wire        [wamf_pkg::WEIGHT_W-1:0] right_weight,
    input  wire        [wamf_pkg::WEIGHT_W-1:0] left_weight,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] wrap_sample,
    input  wire        [wamf_pkg::WEIGHT_W-1:0] wrap_weight,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] new_sample,
    input  wire        [wamf_pkg::WEIGHT_W-1:0] new_weight,
    output logic signed [wamf_pkg::SAMPLE_W-1:0] sample_q,
    output logic        [wamf_pkg::WEIGHT_W-1:0] weight_q
);
    import wamf_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic        [WEIGHT_W-1:0] weight_reg, weight_next;

    // Select sample source
    always_comb
    begin
        unique case (ctl.samp_op)
            OP_RIGHT: sample_next = right_sample;
            OP_LOAD:  sample_next = new_sample;
            OP_WRAP:  sample_next = wrap_sample;
            OP_CLEAR: sample_next = '0;
            default:  sample_next = sample_reg;
        endcase
    end

    // Select weight source
    always_comb
    begin
        unique case (ctl.wgt_op)
            OP_RIGHT: weight_next = right_weight;
            OP_LEFT:  weight_next = left_weight;
            OP_LOAD:  weight_next = new_weight;
            OP_WRAP:  weight_next = wrap_weight;
            default:  weight_next = weight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            weight_reg <= WEIGHT_ONE;
        end
        else
        begin
            sample_reg <= sample_next;
            weight_reg <= weight_next;
        end
    end

    assign sample_q = sample_reg;
    assign weight_q = weight_reg;

endmodule
`default_nettype wire

// ----- src/wamf_sort_cell.sv -----
// One cell of the insertion sorting chain used for the median.
`default_nettype none
module wamf_sort_cell (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 clear,
    input  wire                                 insert,
    input  wire                                 shift,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] key,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] prev_value,
    input  wire                                 prev_valid,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0] next_value,
    input  wire                                 next_valid,
    output logic signed [wamf_pkg::SAMPLE_W-1:0] value_q,
    output logic                                valid_q
);
    import wamf_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic                       valid_reg, valid_next;
    logic                       lt_self, lt_prev;

    // Key belongs here or below; shift the predecessor in if key sorts before it.
    // An empty cell only fills when it is the first empty one in the chain.
    always_comb
    begin
        lt_self    = valid_reg ? (key < value_reg) : prev_valid;
        lt_prev    = prev_valid && (key < prev_value);
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (insert && lt_self)
        begin
            value_next = lt_prev ? prev_value : key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;
    assign valid_q = valid_reg;

endmodule
`default_nettype wire

// ----- src/wamf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module wamf_div #(
    parameter int N_W = 51,
    parameter int D_W = 19
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             start,
    input  wire [N_W-1:0]   dividend,
    input  wire [D_W-1:0]   divisor,
    output logic            done,
    output logic [N_W-1:0]  quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;

    // Shift in one dividend bit and subtract where it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        diff      = trial - {1'b0, div_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/weighted_average_or_median_filter.sv -----
// Top level: sliding-window weighted average or running median filter.
//
// Input channel in_valid/in_ready carries action, sample and weight; one result
// transfer on out_valid/out_ready follows every accepted input transfer.
// Action 0 adds a sample (filtered in modes 1 and 2, passed through otherwise),
// action 1 pushes a weight and reports the weight sum, action 2 clears the window samples.
// The window is a row of cells; for a filtered sample or a weight push it rotates
// once through its n active cells, one position a cycle, feeding a multiply-accumulate,
// the weight sum or a sorting chain. An average then divides the ACC_W-bit accumulator
// magnitude (ACC_W = 48 + log2(MAX_WINDOW)) by the weight sum in the divider, which is
// skipped when the weight sum is zero. A median shifts the sorting chain down (c-1)/2
// places, c = samples in use, then takes cell 0, or the mean of cells 0 and 1 for even c.
// One item is in flight at a time; in_ready is high while the sequencer is idle,
// even while a finished result still waits in the output register.
// A stalled receiver holds the result; a further finished result waits until it drains.
// Reset: samples 0, weights 1.0, fill count 0, mode pass-through, window size 8.
// Config writes on cfg_we apply at once; the user must make them while idle (unchecked).
`default_nettype none
module weighted_average_or_median_filter #(
    parameter int MAX_WINDOW = wamf_pkg::MAX_WINDOW_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire [wamf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire [wamf_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire [wamf_pkg::ACTION_W-1:0]           action,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0]    sample,
    input  wire [wamf_pkg::WEIGHT_W-1:0]           weight,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic signed [wamf_pkg::SAMPLE_W-1:0]   result,
    output logic [wamf_pkg::WSUM_OUT_W-1:0]        weight_sum,
    output logic                                   zero_divisor
);
    import wamf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ACC_W = PROD_W + $clog2(MAX_WINDOW);
    localparam int WS_W  = WEIGHT_W + $clog2(MAX_WINDOW);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_FLUSH    = 7'b0000100,
        ST_DIVCHECK = 7'b0001000,
        ST_DIVWAIT  = 7'b0010000,
        ST_PICK     = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [MODE_W-1:0]  mode_reg;
    logic [WSIZE_W-1:0] wsize_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   c_reg, c_next;
    logic [CNT_W-1:0]   pick_reg, pick_next;
    logic [IDX_W-1:0]   k_reg, k_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_vld_reg, prod_vld_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [WS_W-1:0]          wsum_reg, wsum_next;
    logic                     neg_reg, neg_next;

    logic signed [SAMPLE_W-1:0] pend_res_reg, pend_res_next;
    logic [WSUM_OUT_W-1:0]      pend_ws_reg, pend_ws_next;
    logic                       pend_zero_reg, pend_zero_next;

    logic signed [SAMPLE_W-1:0] out_res_reg, out_res_next;
    logic [WSUM_OUT_W-1:0]      out_ws_reg, out_ws_next;
    logic                       out_zero_reg, out_zero_next;
    logic                       out_valid_reg, out_valid_next;

    logic accept;
    logic filt_mode;
    logic in_span;
    logic scan_last;
    logic div_start;
    logic div_done;
    logic [ACC_W-1:0] div_quo;
    logic [ACC_W-1:0] acc_mag;

    logic sort_clear, sort_insert, sort_shift;
    logic signed [SAMPLE_W:0] med_sum;

    cell_ctl_t                  ctl [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] samp_q [MAX_WINDOW];
    logic [WEIGHT_W-1:0]        wgt_q [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sort_val [MAX_WINDOW];
    logic                       sort_vld [MAX_WINDOW];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PASS;
            wsize_reg <= WSIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FILTER_MODE)
                mode_reg <= cfg_wdata[MODE_W-1:0];
            if (cfg_index == REG_WINDOW_SIZE)
                wsize_reg <= cfg_wdata[WSIZE_W-1:0];
        end
    end

    // Clamp the window size
    always_comb
    begin
        if (wsize_reg < 4'd2)
            n_eff = CNT_W'(2);
        else if (32'(wsize_reg) > MAX_WINDOW)
            n_eff = CNT_W'(MAX_WINDOW);
        else
            n_eff = CNT_W'(wsize_reg);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign filt_mode = (mode_reg == MODE_AVG) || (mode_reg == MODE_MED);
    assign in_span   = (CNT_W'(k_reg) >= (n_reg - c_reg));
    assign scan_last = (CNT_W'(k_reg) == (n_reg - 1'b1));
    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign med_sum   = {sort_val[0][SAMPLE_W-1], sort_val[0]}
                     + {sort_val[1][SAMPLE_W-1], sort_val[1]};

    // Drive each window cell: shift or clear on a transfer, rotate while scanning
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            ctl[i].samp_op = OP_HOLD;
            ctl[i].wgt_op  = OP_HOLD;
            if (accept)
            begin
                if (action == ACT_ADD && filt_mode)
                begin
                    if (CNT_W'(i) < n_eff - 1'b1)
                        ctl[i].samp_op = OP_RIGHT;
                    else if (CNT_W'(i) == n_eff - 1'b1)
                        ctl[i].samp_op = OP_LOAD;
                end
                else if (action == ACT_WEIGHT)
                begin
                    if (i == 0)
                        ctl[i].wgt_op = OP_LOAD;
                    else if (CNT_W'(i) < n_eff)
                        ctl[i].wgt_op = OP_LEFT;
                end
                else if (action == ACT_CLEAR)
                begin
                    ctl[i].samp_op = OP_CLEAR;
                end
            end
            else if (state_reg == ST_SCAN)
            begin
                if (CNT_W'(i) < n_reg - 1'b1)
                begin
                    ctl[i].samp_op = OP_RIGHT;
                    ctl[i].wgt_op  = OP_RIGHT;
                end
                else if (CNT_W'(i) == n_reg - 1'b1)
                begin
                    ctl[i].samp_op = OP_WRAP;
                    ctl[i].wgt_op  = OP_WRAP;
                end
            end
        end
    end

    // Row of window cells
    for (genvar g = 0; g < MAX_WINDOW; g++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] r_s;
        logic [WEIGHT_W-1:0]        r_w;
        logic [WEIGHT_W-1:0]        l_w;
        if (g < MAX_WINDOW - 1)
        begin : g_right
            assign r_s = samp_q[g+1];
            assign r_w = wgt_q[g+1];
        end
        else
        begin : g_edge_r
            assign r_s = '0;
            assign r_w = '0;
        end
        if (g > 0)
        begin : g_left
            assign l_w = wgt_q[g-1];
        end
        else
        begin : g_edge_l
            assign l_w = '0;
        end
        wamf_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl[g]),
            .right_sample (r_s),
            .right_weight (r_w),
            .left_weight  (l_w),
            .wrap_sample  (samp_q[0]),
            .wrap_weight  (wgt_q[0]),
            .new_sample   (sample),
            .new_weight   (weight),
            .sample_q     (samp_q[g]),
            .weight_q     (wgt_q[g])
        );
    end

    assign sort_clear  = accept;
    assign sort_insert = (state_reg == ST_SCAN) && (job_reg == JOB_MED) && in_span;
    assign sort_shift  = (state_reg == ST_PICK) && (pick_reg != '0);

    // Sorting chain for the median
    for (genvar g = 0; g < MAX_WINDOW; g++)
    begin : g_sort
        logic signed [SAMPLE_W-1:0] p_v, n_v;
        logic                       p_ok, n_ok;
        if (g > 0)
        begin : g_prev
            assign p_v  = sort_val[g-1];
            assign p_ok = sort_vld[g-1];
        end
        else
        begin : g_first
            // Valid floor at or below every key: the first cell always may fill
            assign p_v  = {1'b1, {(SAMPLE_W-1){1'b0}}};
            assign p_ok = 1'b1;
        end
        if (g < MAX_WINDOW - 1)
        begin : g_next
            assign n_v  = sort_val[g+1];
            assign n_ok = sort_vld[g+1];
        end
        else
        begin : g_last
            assign n_v  = '0;
            assign n_ok = 1'b0;
        end
        wamf_sort_cell u_sort (
            .clk        (clk),
            .rst_n      (rst_n),
            .clear      (sort_clear),
            .insert     (sort_insert),
            .shift      (sort_shift),
            .key        (samp_q[0]),
            .prev_value (p_v),
            .prev_valid (p_ok),
            .next_value (n_v),
            .next_valid (n_ok),
            .value_q    (sort_val[g]),
            .valid_q    (sort_vld[g])
        );
    end

    wamf_div #(
        .N_W (ACC_W),
        .D_W (WS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (wsum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        n_next         = n_reg;
        fill_next      = fill_reg;
        c_next         = c_reg;
        pick_next      = pick_reg;
        k_next         = k_reg;
        prod_next      = prod_reg;
        prod_vld_next  = 1'b0;
        acc_next       = acc_reg;
        wsum_next      = wsum_reg;
        neg_next       = neg_reg;
        pend_res_next  = pend_res_reg;
        pend_ws_next   = pend_ws_reg;
        pend_zero_next = pend_zero_reg;
        out_res_next   = out_res_reg;
        out_ws_next    = out_ws_reg;
        out_zero_next  = out_zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next         = n_eff;
                    k_next         = '0;
                    acc_next       = '0;
                    wsum_next      = '0;
                    pend_res_next  = '0;
                    pend_ws_next   = '0;
                    pend_zero_next = 1'b0;
                    state_next     = ST_DONE;
                    if (action == ACT_ADD)
                    begin
                        if (filt_mode)
                        begin
                            if (fill_reg < n_eff)
                            begin
                                fill_next = fill_reg + 1'b1;
                                c_next    = fill_reg + 1'b1;
                            end
                            else
                            begin
                                c_next = n_eff;
                            end
                            job_next   = (mode_reg == MODE_AVG) ? JOB_AVG : JOB_MED;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            pend_res_next = sample;
                        end
                    end
                    else if (action == ACT_WEIGHT)
                    begin
                        job_next   = JOB_WSUM;
                        state_next = ST_SCAN;
                    end
                    else if (action == ACT_CLEAR)
                    begin
                        fill_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // Cell 0 holds window position k this cycle
                prod_next     = PROD_W'(samp_q[0]) * PROD_W'($signed({1'b0, wgt_q[0]}));
                prod_vld_next = in_span && (job_reg == JOB_AVG);
                if (prod_vld_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                if (job_reg == JOB_WSUM || (job_reg == JOB_AVG && in_span))
                    wsum_next = wsum_reg + WS_W'(wgt_q[0]);
                k_next = k_reg + 1'b1;
                if (scan_last)
                begin
                    pick_next = (c_reg - 1'b1) >> 1;
                    unique case (job_reg)
                        JOB_AVG:  state_next = ST_FLUSH;
                        JOB_MED:  state_next = ST_PICK;
                        default:
                        begin
                            pend_ws_next = WSUM_OUT_W'(wsum_next);
                            state_next   = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (prod_vld_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
                state_next = ST_DIVCHECK;
            end
            ST_DIVCHECK:
            begin
                if (wsum_reg == '0)
                begin
                    pend_zero_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    neg_next   = acc_reg[ACC_W-1];
                    div_start  = 1'b1;
                    state_next = ST_DIVWAIT;
                end
            end
            ST_DIVWAIT:
            begin
                // Saturate the truncated quotient to 32 bits
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        if (div_quo > {{(ACC_W-SAMPLE_W){1'b0}}, 32'h8000_0000})
                            pend_res_next = 32'sh8000_0000;
                        else
                            pend_res_next = -$signed(div_quo[SAMPLE_W-1:0]);
                    end
                    else
                    begin
                        if (div_quo > {{(ACC_W-SAMPLE_W){1'b0}}, 32'h7fff_ffff})
                            pend_res_next = 32'sh7fff_ffff;
                        else
                            pend_res_next = $signed(div_quo[SAMPLE_W-1:0]);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_PICK:
            begin
                if (pick_reg != '0)
                begin
                    pick_next = pick_reg - 1'b1;
                end
                else
                begin
                    pend_res_next = c_reg[0] ? sort_val[0] : med_sum[SAMPLE_W:1];
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = pend_res_reg;
                    out_ws_next    = pend_ws_reg;
                    out_zero_next  = pend_zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_AVG;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            k_reg         <= '0;
            pick_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            prod_vld_reg  <= prod_vld_next;
            k_reg         <= k_next;
            pick_reg      <= pick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        c_reg         <= c_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        wsum_reg      <= wsum_next;
        neg_reg       <= neg_next;
        pend_res_reg  <= pend_res_next;
        pend_ws_reg   <= pend_ws_next;
        pend_zero_reg <= pend_zero_next;
        out_res_reg   <= out_res_next;
        out_ws_reg    <= out_ws_next;
        out_zero_reg  <= out_zero_next;
    end

    assign out_valid    = out_valid_reg;
    assign result       = out_res_reg;
    assign weight_sum   = out_ws_reg;
    assign zero_divisor = out_zero_reg;

    // A zero divisor always comes with a zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divisor |-> (result == '0))
        else $error("zero_divisor set with nonzero result");

    // A weight sum is only reported on a weight push, never with a filter flag
    a_wsum_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (weight_sum != '0) |-> (result == '0) && !zero_divisor)
        else $error("weight sum reported together with a filter result");

    // Fill count never passes the largest window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_WINDOW)
        else $error("fill count beyond window depth");

    // One item at a time: a transfer closes the input until it is done
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // The divider is started only from its check state
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_DIVCHECK) && (wsum_reg != '0))
        else $error("divider started outside its check state");

endmodule
`default_nettype wire

// ----- bench/weighted_average_or_median_filter_check.sv -----
// Checker for the weighted average / median filter: predicts each result and compares.
module weighted_average_or_median_filter_check (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [wamf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [wamf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire                                   in_valid,
    input  wire                                   in_ready,
    input  wire [wamf_pkg::ACTION_W-1:0]          action,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0]   sample,
    input  wire [wamf_pkg::WEIGHT_W-1:0]          weight,
    input  wire                                   out_valid,
    input  wire                                   out_ready,
    input  wire signed [wamf_pkg::SAMPLE_W-1:0]   result,
    input  wire [wamf_pkg::WSUM_OUT_W-1:0]        weight_sum,
    input  wire                                   zero_divisor,
    output int                                    fail_count,
    output int                                    pending
);
    import wamf_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [WSUM_OUT_W-1:0]      wsum;
        logic                       zdiv;
    } filt_out_t;

    filt_out_t expected_q[$];
    logic [MODE_W-1:0]          mode;
    logic [WSIZE_W-1:0]         wsize;
    logic signed [SAMPLE_W-1:0] samples[MAX_WINDOW_DEF];
    logic [WEIGHT_W-1:0]        weights[MAX_WINDOW_DEF];
    int                         fill;

    assign pending = expected_q.size();

    // Shift a sample in and return how many positions are in use
    function automatic int shift_sample(logic signed [SAMPLE_W-1:0] v, int n);
        for (int i = 0; i + 1 < n; i++) samples[i] = samples[i+1];
        samples[n-1] = v;
        if (fill < n) begin
            fill++;
            return fill;
        end
        return n;
    endfunction

    function automatic filt_out_t filter_item(logic [ACTION_W-1:0] act,
                                              logic signed [SAMPLE_W-1:0] smp,
                                              logic [WEIGHT_W-1:0] wgt);
        filt_out_t r;
        int n;
        int c;
        longint acc;
        longint wtot;
        longint q;
        logic signed [SAMPLE_W-1:0] buf_s[MAX_WINDOW_DEF];
        logic signed [SAMPLE_W-1:0] key;
        int j;
        r = '0;
        n = (wsize < 2) ? 2 : (wsize > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(wsize);
        if (act == ACT_ADD) begin
            if (mode == MODE_AVG) begin
                c = shift_sample(smp, n);
                acc = 0;
                wtot = 0;
                for (int i = n - c; i < n; i++) begin
                    acc += longint'(samples[i]) * longint'({1'b0, weights[i]});
                    wtot += longint'(weights[i]);
                end
                if (wtot == 0) r.zdiv = 1'b1;
                else begin
                    q = acc / wtot;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    r.value = q[31:0];
                end
            end else if (mode == MODE_MED) begin
                c = shift_sample(smp, n);
                for (int i = 0; i < c; i++) buf_s[i] = samples[n-c+i];
                for (int i = 1; i < c; i++) begin
                    key = buf_s[i];
                    j = i;
                    while (j > 0 && buf_s[j-1] > key) begin
                        buf_s[j] = buf_s[j-1];
                        j--;
                    end
                    buf_s[j] = key;
                end
                if (c % 2) r.value = buf_s[c/2];
                else begin
                    q = (longint'(buf_s[c/2-1]) + longint'(buf_s[c/2])) >>> 1;
                    r.value = q[31:0];
                end
            end else r.value = smp;
        end else if (act == ACT_WEIGHT) begin
            for (int i = n - 1; i > 0; i--) weights[i] = weights[i-1];
            weights[0] = wgt;
            q = 0;
            for (int i = 0; i < n; i++) q += longint'(weights[i]);
            r.wsum = q[WSUM_OUT_W-1:0];
        end else if (act == ACT_CLEAR) begin
            for (int i = 0; i < MAX_WINDOW_DEF; i++) samples[i] = '0;
            fill = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        filt_out_t got;
        filt_out_t exp_r;
        if (!rst_n) begin
            mode = MODE_PASS;
            wsize = WSIZE_RESET;
            fill = 0;
            for (int i = 0; i < MAX_WINDOW_DEF; i++) begin
                samples[i] = '0;
                weights[i] = WEIGHT_ONE;
            end
            expected_q.delete();
            fail_count = 0;
        end else begin
            // Compare the result transfer against the oldest prediction
            if (out_valid && out_ready) begin
                got = '{result, weight_sum, zero_divisor};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h/%h/%b", result, weight_sum, zero_divisor);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %h/%h/%b got %h/%h/%b", exp_r.value,
                                     exp_r.wsum, exp_r.zdiv, result, weight_sum, zero_divisor);
                    end
                end
            end
            // Predict from the input transfer
            if (in_valid && in_ready)
                expected_q.push_back(filter_item(action, sample, weight));
            if (cfg_we) begin
                if (cfg_index == REG_FILTER_MODE) mode = cfg_wdata[MODE_W-1:0];
                else wsize = cfg_wdata;
            end
        end
    end

endmodule

// ----- bench/weighted_average_or_median_filter_test.sv -----
// Testbench top for the weighted average / median filter: stimulus and verdict.
module weighted_average_or_median_filter_test;
    import wamf_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ACTION_W-1:0]        action = ACT_ADD;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic [WEIGHT_W-1:0]        weight = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] result;
    logic [WSUM_OUT_W-1:0]      weight_sum;
    logic                       zero_divisor;
    int                         fail_count;
    int                         pending;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    longint                     cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    weighted_average_or_median_filter u_dut (.*);
    weighted_average_or_median_filter_check u_check (.*);

    // Stall the receiver at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // End the run at a generous cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold one transfer on the input channel until it is accepted; valid stays up
    // for the next item, the block is busy in the cycle after every transfer
    task automatic send_item(logic [ACTION_W-1:0] act, logic [31:0] smp, logic [15:0] wgt);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sample <= smp;
        weight <= wgt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(7) << 16;
            1: return 32'h7FFFFFFF - $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) send_item(ACT_ADD, rand_sample(), '0);
            else if (pick < 85) send_item(ACT_WEIGHT, $urandom, rand_weight());
            else if (pick < 95) send_item(ACT_CLEAR, $urandom, 16'($urandom));
            else send_item(2'd3, $urandom, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every action, field extremes, zero weights, pass-through
        send_item(ACT_ADD, 32'h7FFFFFFF, '0);
        send_item(ACT_ADD, 32'h80000000, '0);
        send_item(ACT_WEIGHT, '0, 16'hFFFF);
        send_item(2'd3, 32'hFFFFFFFF, 16'hFFFF);
        drain();
        write_reg(REG_FILTER_MODE, MODE_AVG);
        send_item(ACT_ADD, 32'h7FFFFFFF, '0);
        send_item(ACT_ADD, 32'h7FFFFFFF, '0);
        for (int i = 0; i < 8; i++) send_item(ACT_WEIGHT, '0, '0);
        send_item(ACT_ADD, 32'h00010000, '0);
        send_item(ACT_CLEAR, '0, '0);
        drain();
        write_reg(REG_FILTER_MODE, MODE_MED);
        write_reg(REG_WINDOW_SIZE, 0);
        send_item(ACT_ADD, 32'h80000000, '0);
        send_item(ACT_ADD, 32'h80000001, '0);
        send_item(ACT_ADD, 32'h7FFFFFFF, '0);
        drain();
        write_reg(REG_WINDOW_SIZE, 15);
        send_item(ACT_ADD, 32'hFFFFFFFF, '0);
        send_item(ACT_ADD, 32'h00000002, '0);
        send_item(ACT_ADD, 32'h00000005, '0);
        drain();

        // Random phases over modes, window sizes and idling patterns
        for (int p = 0; p < 24; p++) begin
            write_reg(REG_FILTER_MODE, (p % 4 == 3) ? 3 : p % 4);
            write_reg(REG_WINDOW_SIZE, (p % 6 == 0) ? 15 : (p % 6 == 1) ? 2 :
                      int'($urandom_range(15)));
            case ((p / 4) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            run_phase(75);
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
